// File: rtl/core/atsl_pkg.sv
// Package for the address to symbol lookup block.
// Holds command and status codes, table sizes and the sequencer state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package atsl_pkg;
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_ENTRY  = 3'd1,
    CMD_HEADER = 3'd2,
    CMD_BIND   = 3'd3,
    CMD_LOOKUP = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FILE   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_SEG    = 3'd3,
    ST_BAD_RANGE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HDR_SCAN,
    S_BIND_SCAN,
    S_BIND_APPEND,
    S_LK_SCAN,
    S_BS_ISSUE,
    S_BS_WAIT,
    S_BS_CMP,
    S_FIN_ISSUE,
    S_FIN_WAIT,
    S_FIN_CALC,
    S_OUT
  } state_e;

  // Table sizes; the port widths are fixed to match them.
  localparam int unsigned MAX_FILES    = 8;
  localparam int unsigned ENTRY_DEPTH  = 1024;
  localparam int unsigned MAX_BINDINGS = 16;

  localparam int unsigned AddrW = 24;
  localparam logic [AddrW-1:0] AddrMask = 24'hffffff;
endpackage
`default_nettype wire

// File: rtl/core/atsl_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module atsl_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Read first (a read during a write returns the old data), read registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/address_to_symbol_lookup.sv
// Top level of the address to symbol lookup block.
// Depends on atsl_pkg and atsl_ram.
`timescale 1ns / 1ps
`default_nettype none
// One word is taken at a time; in_stall_o stays high from the accepting edge
// until its result word has been taken, and drops in the cycle after that, so
// the next word can then be taken. Clear, load entry and load header go
// straight to the result state. Bind walks the headers and then the bindings
// one per cycle. Lookup walks the bindings one per cycle, then binary-searches
// the entry RAM; each step passes through compute, registered read and
// compare, for at most log2(count)+1 steps, and then the search ends, the
// best entry is read and the result is formed. The entry RAM is single-port.
// No clearing pass is needed after reset.
module address_to_symbol_lookup (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [9:0]  position_i,
  input  wire logic [23:0] offset_value_i,
  input  wire logic [10:0] entry_count_i,
  input  wire logic [31:0] signature_i,
  input  wire logic [23:0] address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic             rebound_o,
  output logic [2:0]       file_slot_o,
  output logic             has_symbol_o,
  output logic [9:0]       entry_index_o,
  output logic [23:0]      distance_o
);
  import atsl_pkg::*;

  localparam int unsigned FW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned EW = $clog2(ENTRY_DEPTH);
  localparam int unsigned BW = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
  localparam int unsigned BCW = $clog2(MAX_BINDINGS + 1);
  localparam int unsigned FCW = $clog2(MAX_FILES + 1);
  localparam int unsigned SW = EW + 2;

  // Header table and binding table (small, read by index from the sequencer).
  logic [MAX_FILES-1:0] hvalid_q;
  logic [31:0]   hsig_q   [MAX_FILES];
  logic [23:0]   hlen_q   [MAX_FILES];
  logic [EW-1:0] hfirst_q [MAX_FILES];
  logic [EW:0]   hcount_q [MAX_FILES];
  logic [FW-1:0] bslot_q  [MAX_BINDINGS];
  logic [23:0]   bbase_q  [MAX_BINDINGS];
  logic [BCW-1:0] bcount_q;

  // Captured input word.
  logic [2:0]  cmd_q, slot_q;
  logic [9:0]  pos_q;
  logic [23:0] val_q, addr_q;
  logic [10:0] cnt_q;
  logic [31:0] sig_q;

  state_e state_q, state_d;
  logic [BCW-1:0] idx_q;
  logic [FCW-1:0] hidx_q;
  logic [FW-1:0]  match_q;
  logic [FW-1:0]  cur_q;
  logic [23:0]    rel_q;
  logic signed [SW-1:0] lo_q, hi_q, best_q, mid_q;

  logic [2:0]  st_q;
  logic        reb_q, has_q;
  logic [2:0]  fs_q;
  logic [9:0]  ei_q;
  logic [23:0] dist_q;

  // Entry RAM port.
  logic          ram_we;
  logic [EW-1:0] ram_addr;
  logic [23:0]   ram_rdata;

  atsl_ram #(.Width(24), .Depth(ENTRY_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Shared unit: current binding, its slot and range check.
  logic [BW-1:0]  bi;
  logic [FW-1:0]  bs;
  logic [24:0]    rend;
  logic           in_rng;
  logic [FW-1:0]  hi_idx;
  logic           s_ok;
  assign bi     = idx_q[BW-1:0];
  assign bs     = bslot_q[bi];
  assign hi_idx = hidx_q[FW-1:0];
  assign s_ok   = ({{(32-FW){1'b0}}, bs} < MAX_FILES) && hvalid_q[bs];
  assign rend   = {1'b0, bbase_q[bi]} + {1'b0, hlen_q[bs]};
  assign in_rng = (addr_q >= bbase_q[bi]) && ({1'b0, addr_q} < rend);

  logic [SW-1:0]  mid_sum;
  logic [EW-1:0]  mid_pos, best_pos;
  assign mid_sum  = (lo_q + hi_q) >>> 1;
  assign mid_pos  = hfirst_q[cur_q] + mid_q[EW-1:0];
  assign best_pos = hfirst_q[cur_q] + best_q[EW-1:0];

  logic [EW+1:0] hdr_end;
  assign hdr_end = {2'b00, pos_q[EW-1:0]} + {1'b0, cnt_q[EW:0]};
  logic hdr_bad;
  assign hdr_bad = ({{(32-3){1'b0}}, slot_q} >= MAX_FILES) || (cnt_q > ENTRY_DEPTH)
                   || (hdr_end > ENTRY_DEPTH) || ({22'd0, pos_q} >= ENTRY_DEPTH);

  // The read address is held through the cycle before the data is used.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = pos_q[EW-1:0];
    if (state_q == S_BS_WAIT) ram_addr = mid_pos;
    if (state_q == S_FIN_ISSUE || state_q == S_FIN_WAIT) ram_addr = best_pos;
    if (state_q == S_OUT && cmd_q == CMD_ENTRY && !out_valid_o
        && {22'd0, pos_q} < ENTRY_DEPTH) begin
      ram_we = 1'b1;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) begin
        case (cmd_i)
          CMD_BIND:   state_d = S_HDR_SCAN;
          CMD_LOOKUP: state_d = S_LK_SCAN;
          default:    state_d = S_OUT;
        endcase
      end
      S_HDR_SCAN: begin
        if (hidx_q == FCW'(MAX_FILES)) state_d = S_OUT;
        else if (hvalid_q[hi_idx] && hsig_q[hi_idx] == sig_q) state_d = S_BIND_SCAN;
      end
      S_BIND_SCAN: begin
        if (idx_q == bcount_q) state_d = S_BIND_APPEND;
        else if (s_ok && hsig_q[bs] == sig_q) state_d = S_OUT;
      end
      S_BIND_APPEND: state_d = S_OUT;
      S_LK_SCAN: begin
        if (idx_q == bcount_q) state_d = S_OUT;
        else if (s_ok && in_rng) state_d = S_BS_ISSUE;
      end
      S_BS_ISSUE: state_d = (lo_q > hi_q) ? S_FIN_ISSUE : S_BS_WAIT;
      S_BS_WAIT:  state_d = S_BS_CMP;
      S_BS_CMP:   state_d = S_BS_ISSUE;
      S_FIN_ISSUE: state_d = best_q[SW-1] ? S_FIN_CALC : S_FIN_WAIT;
      S_FIN_WAIT:  state_d = S_FIN_CALC;
      S_FIN_CALC:  state_d = S_OUT;
      S_OUT: if (out_valid_o && !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: tables, counters, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q    <= '0;
      bcount_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (state_q == S_OUT && !out_valid_o) begin
        out_valid_o <= 1'b1;
        if (cmd_q == CMD_CLEAR) begin
          hvalid_q <= '0;
          bcount_q <= '0;
        end
        if (cmd_q == CMD_HEADER && !hdr_bad) hvalid_q[slot_q[FW-1:0]] <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == S_BIND_APPEND && bcount_q < BCW'(MAX_BINDINGS)) begin
        bcount_q <= bcount_q + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i; slot_q <= slot_i; pos_q <= position_i;
      val_q <= offset_value_i; cnt_q <= entry_count_i; sig_q <= signature_i;
      addr_q <= address_i & AddrMask;
      idx_q <= '0; hidx_q <= '0;
      st_q <= ST_OK; reb_q <= 1'b0; has_q <= 1'b0;
      fs_q <= '0; ei_q <= '0; dist_q <= '0;
      if (cmd_i == CMD_BIND) st_q <= ST_NO_FILE;
      if (cmd_i == CMD_LOOKUP) st_q <= ST_NO_SEG;
    end
    case (state_q)
      S_HDR_SCAN: begin
        if (hidx_q != FCW'(MAX_FILES)) begin
          if (hvalid_q[hi_idx] && hsig_q[hi_idx] == sig_q) begin
            match_q <= hi_idx;
            st_q <= ST_OK;
          end
          hidx_q <= hidx_q + 1'b1;
        end
      end
      S_BIND_SCAN: begin
        if (idx_q != bcount_q) begin
          if (s_ok && hsig_q[bs] == sig_q) begin
            bbase_q[bi] <= addr_q;
            reb_q <= 1'b1;
            fs_q <= 3'(bs);
          end
          idx_q <= idx_q + 1'b1;
        end
      end
      S_BIND_APPEND: begin
        if (bcount_q < BCW'(MAX_BINDINGS)) begin
          bslot_q[bcount_q[BW-1:0]] <= match_q;
          bbase_q[bcount_q[BW-1:0]] <= addr_q;
          fs_q <= 3'(match_q);
        end else begin
          st_q <= ST_FULL;
        end
      end
      S_LK_SCAN: begin
        if (idx_q != bcount_q) begin
          if (s_ok && in_rng) begin
            cur_q <= bs;
            st_q  <= ST_OK;
            fs_q  <= 3'(bs);
            rel_q <= addr_q - bbase_q[bi];
            lo_q  <= '0;
            hi_q  <= SW'($signed({1'b0, hcount_q[bs]})) - SW'(1);
            best_q <= '1;
          end
          idx_q <= idx_q + 1'b1;
        end
      end
      S_BS_ISSUE: mid_q <= mid_sum;
      S_BS_WAIT: ;
      S_BS_CMP: begin
        if (ram_rdata <= rel_q) begin
          best_q <= mid_q;
          lo_q <= mid_q + SW'(1);
        end else begin
          hi_q <= mid_q - SW'(1);
        end
      end
      S_FIN_CALC: begin
        if (best_q[SW-1]) begin
          dist_q <= rel_q;
        end else begin
          has_q  <= 1'b1;
          ei_q   <= 10'(best_pos);
          dist_q <= rel_q - ram_rdata;
        end
      end
      S_OUT: begin
        if (!out_valid_o && cmd_q == CMD_HEADER) begin
          if (hdr_bad) begin
            st_q <= ST_BAD_RANGE;
          end else begin
            hsig_q[slot_q[FW-1:0]]   <= sig_q;
            hlen_q[slot_q[FW-1:0]]   <= val_q;
            hfirst_q[slot_q[FW-1:0]] <= pos_q[EW-1:0];
            hcount_q[slot_q[FW-1:0]] <= cnt_q[EW:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Result word; status_o is st_q, but a bad header is flagged from cmd_q and hdr_bad directly.
  assign status_o      = (cmd_q == CMD_HEADER && hdr_bad) ? ST_BAD_RANGE : st_q;
  assign rebound_o     = reb_q;
  assign file_slot_o   = fs_q;
  assign has_symbol_o  = has_q;
  assign entry_index_o = ei_q;
  assign distance_o    = dist_q;
endmodule
`default_nettype wire

// File: rtl/core/atsl_checker.sv
// Port-level assertions for the address to symbol lookup block, with their bind.
// Depends on atsl_pkg and address_to_symbol_lookup.
`timescale 1ns / 1ps
`default_nettype none
module atsl_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic        has_symbol_o,
  input wire logic [23:0] distance_o
);
  import atsl_pkg::*;

  // A word is only taken while no result is pending.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");

  // An accepted word blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");

  // A found symbol always comes with status ok.
  a_symbol_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_symbol_o) |-> (status_o == ST_OK)) else $error("symbol with error");

  // A stalled result stays valid and its distance holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(distance_o)))
    else $error("result changed under stall");
endmodule

bind address_to_symbol_lookup atsl_props u_atsl_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .has_symbol_o (has_symbol_o),
  .distance_o   (distance_o)
);
`default_nettype wire
